>>> src/mlsm_pkg.sv
// shared types, constants and microcode for the x25519 ladder block
// no dependencies
package mlsm_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = 4;
    localparam int FE_BITS    = 256;
    localparam int FIELD_BITS = 255;
    localparam int A24_BITS   = 32;
    localparam int NBITS_W    = 9;
    localparam int RF_DEPTH   = 16;
    localparam int RF_AW      = 4;

    // 2^255 - 19
    localparam logic [FE_BITS-1:0] PRIME = {1'b0, {247{1'b1}}, 8'hed};

    localparam logic [1:0] MODE_SCALAR = 2'd0;
    localparam logic [1:0] MODE_COORD  = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;

    localparam logic CFG_A24  = 1'b0;
    localparam logic CFG_BITS = 1'b1;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef logic [4:0] opnd_t;

    localparam opnd_t R_X1   = 5'd0;
    localparam opnd_t R_X2   = 5'd1;
    localparam opnd_t R_Z2   = 5'd2;
    localparam opnd_t R_X3   = 5'd3;
    localparam opnd_t R_Z3   = 5'd4;
    localparam opnd_t R_A    = 5'd5;
    localparam opnd_t R_AA   = 5'd6;
    localparam opnd_t R_B    = 5'd7;
    localparam opnd_t R_BB   = 5'd8;
    localparam opnd_t R_E    = 5'd9;
    localparam opnd_t R_DA   = 5'd10;
    localparam opnd_t R_CB   = 5'd11;
    localparam opnd_t R_T    = 5'd12;
    localparam opnd_t R_ACC  = 5'd13;
    localparam opnd_t R_ZERO = 5'd16;
    localparam opnd_t R_ONE  = 5'd17;
    localparam opnd_t R_BASE = 5'd18;
    localparam opnd_t R_K24  = 5'd19;

    typedef struct packed {
        alu_op_t op;
        opnd_t   dst;
        opnd_t   src_a;
        opnd_t   src_b;
    } uop_t;

    localparam logic [4:0] INIT_LAST   = 5'd5;
    localparam logic [4:0] LADDER_LAST = 5'd17;

    function automatic uop_t mk(alu_op_t op, opnd_t d, opnd_t a, opnd_t b);
        uop_t u;
        u.op    = op;
        u.dst   = d;
        u.src_a = a;
        u.src_b = b;
        return u;
    endfunction

    function automatic uop_t init_uop(logic [4:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:    u = mk(ALU_ADD, R_X1, R_BASE, R_ZERO);
            5'd1:    u = mk(ALU_ADD, R_X2, R_ONE, R_ZERO);
            5'd2:    u = mk(ALU_ADD, R_Z2, R_ZERO, R_ZERO);
            5'd3:    u = mk(ALU_ADD, R_X3, R_X1, R_ZERO);
            5'd4:    u = mk(ALU_ADD, R_Z3, R_ONE, R_ZERO);
            default: u = mk(ALU_ADD, R_ACC, R_ONE, R_ZERO);
        endcase
        return u;
    endfunction

    function automatic uop_t ladder_uop(logic [4:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:    u = mk(ALU_ADD, R_A, R_X2, R_Z2);
            5'd1:    u = mk(ALU_MUL, R_AA, R_A, R_A);
            5'd2:    u = mk(ALU_SUB, R_B, R_X2, R_Z2);
            5'd3:    u = mk(ALU_MUL, R_BB, R_B, R_B);
            5'd4:    u = mk(ALU_SUB, R_E, R_AA, R_BB);
            5'd5:    u = mk(ALU_ADD, R_T, R_X3, R_Z3);
            5'd6:    u = mk(ALU_MUL, R_CB, R_T, R_B);
            5'd7:    u = mk(ALU_SUB, R_T, R_X3, R_Z3);
            5'd8:    u = mk(ALU_MUL, R_DA, R_T, R_A);
            5'd9:    u = mk(ALU_ADD, R_T, R_DA, R_CB);
            5'd10:   u = mk(ALU_MUL, R_X3, R_T, R_T);
            5'd11:   u = mk(ALU_SUB, R_T, R_DA, R_CB);
            5'd12:   u = mk(ALU_MUL, R_T, R_T, R_T);
            5'd13:   u = mk(ALU_MUL, R_Z3, R_X1, R_T);
            5'd14:   u = mk(ALU_MUL, R_X2, R_AA, R_BB);
            5'd15:   u = mk(ALU_MUL, R_T, R_K24, R_E);
            5'd16:   u = mk(ALU_ADD, R_T, R_AA, R_T);
            default: u = mk(ALU_MUL, R_Z2, R_E, R_T);
        endcase
        return u;
    endfunction

    // conditional swap done by renaming x2/z2 against x3/z3
    function automatic opnd_t phys(opnd_t c, logic m);
        opnd_t r;
        r = c;
        if (m)
        begin
            if (c == R_X2)
                r = R_X3;
            else if (c == R_X3)
                r = R_X2;
            else if (c == R_Z2)
                r = R_Z3;
            else if (c == R_Z3)
                r = R_Z2;
        end
        return r;
    endfunction

endpackage

>>> src/mlsm_regfile.sv
// field element register file, one write and two registered read ports
// depends on mlsm_pkg
module mlsm_regfile (
    input  logic                         clk,
    input  logic                         we,
    input  logic [mlsm_pkg::RF_AW-1:0]   waddr,
    input  logic [mlsm_pkg::FE_BITS-1:0] wdata,
    input  logic [mlsm_pkg::RF_AW-1:0]   raddr_a,
    input  logic [mlsm_pkg::RF_AW-1:0]   raddr_b,
    output logic [mlsm_pkg::FE_BITS-1:0] rdata_a,
    output logic [mlsm_pkg::FE_BITS-1:0] rdata_b
);
    import mlsm_pkg::*;

    logic [FE_BITS-1:0] mem [RF_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> src/mlsm_alu.sv
// modular add, subtract and bit-serial multiply mod 2^255-19
// depends on mlsm_pkg
module mlsm_alu (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mlsm_pkg::alu_req_t           req,
    input  logic [mlsm_pkg::FE_BITS-1:0] a_in,
    input  logic [mlsm_pkg::FE_BITS-1:0] b_in,
    output logic                         done,
    output logic [mlsm_pkg::FE_BITS-1:0] y
);
    import mlsm_pkg::*;

    logic               run_reg;
    logic               done_reg;
    alu_op_t            op_reg;
    logic [7:0]         cnt_reg;
    logic [FE_BITS-1:0] a_reg;
    logic [FE_BITS-1:0] b_reg;
    logic [FE_BITS-1:0] acc_reg;
    logic [FE_BITS-1:0] y_reg;

    logic [FE_BITS-1:0] mul_val;
    logic [FE_BITS-1:0] add_val;
    logic [FE_BITS-1:0] sub_val;
    logic [FE_BITS:0]   diff;

    // value below 3p down to below p
    function automatic logic [FE_BITS-1:0] reduce3(logic [FE_BITS+1:0] t);
        logic [FE_BITS+1:0] d1;
        logic [FE_BITS+1:0] d2;
        logic [FE_BITS-1:0] r;
        d1 = t - {2'b00, PRIME};
        d2 = t - {1'b0, PRIME, 1'b0};
        if (!d2[FE_BITS+1])
            r = d2[FE_BITS-1:0];
        else if (!d1[FE_BITS+1])
            r = d1[FE_BITS-1:0];
        else
            r = t[FE_BITS-1:0];
        return r;
    endfunction

    always_comb
    begin
        mul_val = reduce3({1'b0, acc_reg, 1'b0}
                          + (a_reg[FE_BITS-1] ? {2'b00, b_reg} : '0));
        add_val = reduce3({2'b00, a_reg} + {2'b00, b_reg});
        diff    = {1'b0, a_reg} - {1'b0, b_reg};
        sub_val = diff[FE_BITS] ? (diff[FE_BITS-1:0] + PRIME) : diff[FE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_ADD;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            op_reg   <= req.op;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 8'd1;
            if (op_reg != ALU_MUL || cnt_reg == 8'hff)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
            done_reg <= 1'b0;
    end

    // operand shift line, accumulator and result
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            unique case (op_reg)
                ALU_MUL:
                begin
                    a_reg   <= {a_reg[FE_BITS-2:0], 1'b0};
                    acc_reg <= mul_val;
                    y_reg   <= mul_val;
                end
                ALU_SUB: y_reg <= sub_val;
                default: y_reg <= add_val;
            endcase
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

>>> src/montgomery_ladder_scalar_mult.sv
// x25519 montgomery ladder: word loads, microcode sequencer, result words
// depends on mlsm_pkg, mlsm_regfile, mlsm_alu
// a multiply works through one multiplier bit per cycle
// inversion is 508 multiplies
// after the start word the ladder runs over n scalar bits, then the inversion;
// then 4 result words, one per cycle; one run at a time, loads only while not busy
// reset clears control and sets a24 to 121665 and scalar bits to 255
module montgomery_ladder_scalar_mult (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [1:0]                     mode,
    input  logic [1:0]                     word_index,
    input  logic [mlsm_pkg::WORD_BITS-1:0] word_value,
    output logic                           busy,
    input  logic                           cfg_write,
    input  logic                           cfg_addr,
    input  logic [mlsm_pkg::A24_BITS-1:0]  cfg_data,
    output logic                           result_valid,
    output logic [mlsm_pkg::WORD_BITS-1:0] result_word,
    output logic [1:0]                     result_index,
    output logic                           last_word
);
    import mlsm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_START = 5'b00100,
        S_WAIT  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        P_INIT   = 4'b0001,
        P_LADDER = 4'b0010,
        P_INV    = 4'b0100,
        P_FIN    = 4'b1000
    } prog_t;

    state_t state_reg, state_next;
    prog_t  prog_reg, prog_next;
    logic [4:0] pc_reg, pc_next;
    logic [7:0] bit_reg, bit_next;
    logic [7:0] inv_reg, inv_next;
    logic [1:0] out_cnt_reg, out_cnt_next;
    logic [A24_BITS-1:0] a24_reg;
    logic [NBITS_W-1:0]  bits_reg;

    logic [WORD_COUNT-1:0][WORD_BITS-1:0] scalar_reg;
    logic [WORD_COUNT-1:0][WORD_BITS-1:0] base_reg;
    logic [FE_BITS-1:0] res_reg;

    logic [NBITS_W-1:0] n_bits;
    logic               accept;
    logic               kt;
    logic               swap_m;
    uop_t               uop;
    opnd_t              pa, pb, pd;
    logic [FE_BITS-1:0] rdata_a, rdata_b, opa, opb;
    alu_req_t           req;
    logic               alu_done;
    logic [FE_BITS-1:0] alu_y;
    logic               rf_we;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign n_bits = (bits_reg > 9'd256) ? 9'd256 : bits_reg;
    assign kt     = scalar_reg[bit_reg[7:6]][bit_reg[5:0]];
    assign swap_m = (prog_reg == P_LADDER) && kt;

    always_comb
    begin
        unique case (prog_reg)
            P_INIT:   uop = init_uop(pc_reg);
            P_LADDER: uop = ladder_uop(pc_reg);
            P_INV:    uop = (pc_reg == 5'd0) ? mk(ALU_MUL, R_ACC, R_ACC, R_ACC)
                                             : mk(ALU_MUL, R_ACC, R_ACC, R_Z2);
            default:  uop = mk(ALU_MUL, R_T, R_X2, R_ACC);
        endcase
    end

    assign pa = phys(uop.src_a, swap_m);
    assign pb = phys(uop.src_b, swap_m);
    assign pd = phys(uop.dst, swap_m);

    function automatic logic [FE_BITS-1:0] opsel(opnd_t c, logic [FE_BITS-1:0] rd,
                                                 logic [FE_BITS-1:0] base,
                                                 logic [A24_BITS-1:0] k24);
        logic [FE_BITS-1:0] v;
        if (c == R_ZERO)
            v = '0;
        else if (c == R_ONE)
            v = {{(FE_BITS-1){1'b0}}, 1'b1};
        else if (c == R_BASE)
            v = base;
        else if (c == R_K24)
            v = {{(FE_BITS-A24_BITS){1'b0}}, k24};
        else
            v = rd;
        return v;
    endfunction

    assign opa = opsel(pa, rdata_a, base_reg, a24_reg);
    assign opb = opsel(pb, rdata_b, base_reg, a24_reg);

    assign req.start = (state_reg == S_START);
    assign req.op    = uop.op;
    assign rf_we     = (state_reg == S_WAIT) && alu_done;

    mlsm_regfile u_rf (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (pd[RF_AW-1:0]),
        .wdata   (alu_y),
        .raddr_a (pa[RF_AW-1:0]),
        .raddr_b (pb[RF_AW-1:0]),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    mlsm_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .a_in  (opa),
        .b_in  (opb),
        .done  (alu_done),
        .y     (alu_y)
    );

    always_comb
    begin
        state_next   = state_reg;
        prog_next    = prog_reg;
        pc_next      = pc_reg;
        bit_next     = bit_reg;
        inv_next     = inv_reg;
        out_cnt_next = out_cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && mode == MODE_START)
                begin
                    state_next = S_READ;
                    prog_next  = P_INIT;
                    pc_next    = '0;
                end
            end
            S_READ:  state_next = S_START;
            S_START: state_next = S_WAIT;
            S_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = S_READ;
                    unique case (prog_reg)
                        P_INIT:
                        begin
                            if (pc_reg != INIT_LAST)
                                pc_next = pc_reg + 5'd1;
                            else if (n_bits == '0)
                            begin
                                prog_next = P_INV;
                                pc_next   = '0;
                                inv_next  = 8'(FIELD_BITS - 1);
                            end
                            else
                            begin
                                prog_next = P_LADDER;
                                pc_next   = '0;
                                bit_next  = 8'(n_bits - 9'd1);
                            end
                        end
                        P_LADDER:
                        begin
                            pc_next = '0;
                            if (pc_reg != LADDER_LAST)
                                pc_next = pc_reg + 5'd1;
                            else if (bit_reg == '0)
                            begin
                                prog_next = P_INV;
                                inv_next  = 8'(FIELD_BITS - 1);
                            end
                            else
                                bit_next = bit_reg - 8'd1;
                        end
                        P_INV:
                        begin
                            // exponent p-2 has bits two and four clear
                            if (pc_reg == 5'd0 && inv_reg != 8'd2 && inv_reg != 8'd4)
                                pc_next = 5'd1;
                            else
                            begin
                                pc_next = '0;
                                if (inv_reg == '0)
                                    prog_next = P_FIN;
                                else
                                    inv_next = inv_reg - 8'd1;
                            end
                        end
                        default:
                        begin
                            state_next   = S_OUT;
                            out_cnt_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                out_cnt_next = out_cnt_reg + 2'd1;
                if (out_cnt_reg == 2'(WORD_COUNT - 1))
                    state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            prog_reg    <= P_INIT;
            pc_reg      <= '0;
            bit_reg     <= '0;
            inv_reg     <= '0;
            out_cnt_reg <= '0;
            a24_reg     <= 32'd121665;
            bits_reg    <= 9'd255;
        end
        else
        begin
            state_reg   <= state_next;
            prog_reg    <= prog_next;
            pc_reg      <= pc_next;
            bit_reg     <= bit_next;
            inv_reg     <= inv_next;
            out_cnt_reg <= out_cnt_next;
            if (cfg_write)
            begin
                if (cfg_addr == CFG_A24)
                    a24_reg <= cfg_data;
                else
                    bits_reg <= cfg_data[NBITS_W-1:0];
            end
        end
    end

    // operand words and the result shift line
    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_SCALAR)
            scalar_reg[word_index] <= word_value;
        if (accept && mode == MODE_COORD)
            base_reg[word_index] <= word_value;
        if (state_reg == S_WAIT && alu_done && prog_reg == P_FIN)
            res_reg <= alu_y;
        else if (state_reg == S_OUT)
            res_reg <= {{WORD_BITS{1'b0}}, res_reg[FE_BITS-1:WORD_BITS]};
    end

    assign result_valid = (state_reg == S_OUT);
    assign result_word  = res_reg[WORD_BITS-1:0];
    assign result_index = out_cnt_reg;
    assign last_word    = result_valid && (out_cnt_reg == 2'(WORD_COUNT - 1));

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_START) |=> busy)
        else $error("start word did not launch a run");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == S_WAIT))
        else $error("alu finished outside of wait");

    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_word) |=> (result_valid
            && result_index == $past(result_index) + 2'd1))
        else $error("result words not consecutive");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        last_word |=> !busy)
        else $error("block busy after last result word");

endmodule

>>> sim/tb_top.sv
// testbench for the x25519 montgomery ladder block: directed table, then random words
// depends on mlsm_pkg and montgomery_ladder_scalar_mult; field math predictor built in
`timescale 1ns / 100ps

module tb_top;
    import mlsm_pkg::*;

    typedef logic [FE_BITS-1:0] fe_t;

    typedef struct {
        logic [WORD_BITS-1:0] word;
        logic [1:0]           index;
        logic                 last;
    } uword_t;

    typedef struct {
        logic                 set_cfg;
        logic [31:0]          a24;
        logic [8:0]           nbits;
        logic [1:0]           mode;
        logic [1:0]           index;
        logic [WORD_BITS-1:0] value;
        logic                 zero_result;
    } row_t;

    localparam int WATCHDOG = 4000000;
    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic [1:0]           mode;
    logic [1:0]           word_index;
    logic [WORD_BITS-1:0] word_value;
    logic                 busy;
    logic                 cfg_write;
    logic                 cfg_addr;
    logic [A24_BITS-1:0]  cfg_data;
    logic                 result_valid;
    logic [WORD_BITS-1:0] result_word;
    logic [1:0]           result_index;
    logic                 last_word;

    montgomery_ladder_scalar_mult uut (.*);

    // predictor copy of the block's loaded words and registers
    logic [WORD_BITS-1:0] scalar_words [WORD_COUNT];
    logic [WORD_BITS-1:0] coord_words [WORD_COUNT];
    logic [31:0]          a24_reg;
    logic [8:0]           nbits_reg;
    uword_t               pending_words [$];
    int                   fails;
    int                   quiet_cycles;
    bit                   no_idle;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic fe_t fmul(fe_t a, fe_t b);
        logic [2*FE_BITS-1:0] t;
        t = {{FE_BITS{1'b0}}, a} * {{FE_BITS{1'b0}}, b};
        return fe_t'(t % {{FE_BITS{1'b0}}, PRIME});
    endfunction

    function automatic fe_t fadd(fe_t a, fe_t b);
        logic [FE_BITS:0] t;
        t = {1'b0, a} + {1'b0, b};
        return fe_t'(t % {1'b0, PRIME});
    endfunction

    function automatic fe_t fsub(fe_t a, fe_t b);
        logic [FE_BITS:0] t;
        t = {1'b0, a} + {1'b0, PRIME} - {1'b0, b};
        return fe_t'(t % {1'b0, PRIME});
    endfunction

    // affine u of scalar times base point, all values kept canonical
    function automatic fe_t ladder_u();
        fe_t x1, x2, z2, x3, z3, a, aa, b, bb, e, da, cb, t, k24, acc, sc;
        logic [FE_BITS:0] wide;
        logic swap, kt;
        int n;
        wide = {1'b0, coord_words[3], coord_words[2], coord_words[1], coord_words[0]};
        x1 = fe_t'(wide % {1'b0, PRIME});
        sc = {scalar_words[3], scalar_words[2], scalar_words[1], scalar_words[0]};
        x2 = 1; z2 = 0; x3 = x1; z3 = 1;
        k24 = fe_t'(a24_reg);
        swap = 1'b0;
        n = (nbits_reg > 256) ? 256 : int'(nbits_reg);
        for (int i = n - 1; i >= 0; i--)
        begin
            kt = sc[i];
            if (swap ^ kt)
            begin
                t = x2; x2 = x3; x3 = t;
                t = z2; z2 = z3; z3 = t;
            end
            swap = kt;
            a  = fadd(x2, z2);
            aa = fmul(a, a);
            b  = fsub(x2, z2);
            bb = fmul(b, b);
            e  = fsub(aa, bb);
            cb = fmul(fadd(x3, z3), b);
            da = fmul(fsub(x3, z3), a);
            t  = fadd(da, cb);
            x3 = fmul(t, t);
            t  = fsub(da, cb);
            z3 = fmul(x1, fmul(t, t));
            x2 = fmul(aa, bb);
            z2 = fmul(e, fadd(aa, fmul(k24, e)));
        end
        if (swap)
        begin
            x2 = x3;
            z2 = z3;
        end
        // z2^(p-2), zero stays zero
        acc = 1;
        t = PRIME - 2;
        for (int i = FIELD_BITS - 1; i >= 0; i--)
        begin
            acc = fmul(acc, acc);
            if (t[i])
                acc = fmul(acc, z2);
        end
        return fmul(x2, acc);
    endfunction

    task automatic predict_word(logic [1:0] m, logic [1:0] idx, logic [63:0] v, logic zero_res);
        fe_t u;
        uword_t w;
        if (m == MODE_SCALAR)
            scalar_words[idx] = v;
        else if (m == MODE_COORD)
            coord_words[idx] = v;
        else if (m == MODE_START)
        begin
            u = zero_res ? '0 : ladder_u();
            for (int k = 0; k < WORD_COUNT; k++)
            begin
                w.word  = u[k*WORD_BITS +: WORD_BITS];
                w.index = 2'(k);
                w.last  = (k == WORD_COUNT - 1);
                pending_words.push_back(w);
            end
        end
    endtask

    // block idle: every run finished, plus margin for loads still settling
    task automatic wait_idle();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(logic [31:0] a24, logic [8:0] nbits);
        cfg_write <= 1'b1;
        cfg_addr  <= CFG_A24;
        cfg_data  <= a24;
        @(posedge clk);
        cfg_addr  <= CFG_BITS;
        cfg_data  <= 32'(nbits);
        @(posedge clk);
        cfg_write <= 1'b0;
        a24_reg   = a24;
        nbits_reg = nbits;
    endtask

    task automatic send_word(logic [1:0] m, logic [1:0] idx, logic [63:0] v, logic zero_res);
        if (!no_idle && $urandom_range(0, 99) < 14)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= m;
        word_index <= idx;
        word_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_word(m, idx, v, zero_res);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word %h index %0d", result_word, result_index);
                fails++;
            end
            else
            begin
                uword_t w;
                w = pending_words.pop_front();
                if (result_word !== w.word)
                begin
                    $error("result_word expected %h actual %h", w.word, result_word);
                    fails++;
                end
                if (result_index !== w.index)
                begin
                    $error("result_index expected %0d actual %0d", w.index, result_index);
                    fails++;
                end
                if (last_word !== w.last)
                begin
                    $error("last_word expected %0d actual %0d", w.last, last_word);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || result_valid || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    row_t rows [24];

    initial
    begin
        int n_start;
        int r;
        logic [1:0] m;
        rows = '{
            // no ladder steps: z2 stays zero, result is zero
            '{1, 32'd121665, 9'd0, MODE_SCALAR, 2'd0, ONES, 0},
            '{0, 0, 0, MODE_SCALAR, 2'd1, ONES, 0},
            '{0, 0, 0, MODE_SCALAR, 2'd2, ONES, 0},
            '{0, 0, 0, MODE_SCALAR, 2'd3, ONES, 0},
            '{0, 0, 0, MODE_COORD, 2'd0, 64'd9, 0},
            '{0, 0, 0, MODE_COORD, 2'd1, 64'd0, 0},
            '{0, 0, 0, MODE_COORD, 2'd2, 64'd0, 0},
            '{0, 0, 0, MODE_COORD, 2'd3, 64'd0, 0},
            '{0, 0, 0, 2'd3, 2'd3, ONES, 0},
            '{0, 0, 0, MODE_START, 2'd0, 64'd0, 1},
            '{1, 32'd121665, 9'd12, MODE_START, 2'd3, ONES, 0},
            // coordinate above the prime
            '{0, 0, 0, MODE_COORD, 2'd0, ONES, 0},
            '{0, 0, 0, MODE_COORD, 2'd1, ONES, 0},
            '{0, 0, 0, MODE_COORD, 2'd2, ONES, 0},
            '{0, 0, 0, MODE_COORD, 2'd3, ONES, 0},
            '{1, 32'd0, 9'd1, MODE_START, 2'd1, 64'd0, 0},
            '{0, 0, 0, MODE_SCALAR, 2'd0, 64'd0, 0},
            '{0, 0, 0, MODE_SCALAR, 2'd1, 64'd0, 0},
            '{0, 0, 0, MODE_SCALAR, 2'd2, 64'd0, 0},
            '{0, 0, 0, MODE_SCALAR, 2'd3, 64'd0, 0},
            // zero scalar lands on the point at infinity
            '{1, 32'hffff_ffff, 9'd9, MODE_START, 2'd2, ONES, 1},
            '{0, 0, 0, MODE_SCALAR, 2'd3, 64'h8000_0000_0000_0001, 0},
            '{0, 0, 0, MODE_COORD, 2'd0, 64'd9, 0},
            // bit count saturates to the full 256
            '{1, 32'd121665, 9'h1ff, MODE_START, 2'd0, 64'h5a5a_a5a5_0f0f_f0f0, 0}
        };
        fails = 0;
        no_idle = 1'b0;
        a24_reg = 32'd121665;
        nbits_reg = 9'd255;
        rst_n <= 1'b0;
        start <= 1'b0;
        mode <= MODE_SCALAR;
        word_index <= 2'd0;
        word_value <= '0;
        cfg_write <= 1'b0;
        cfg_addr <= CFG_A24;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].set_cfg)
            begin
                start <= 1'b0;
                wait_idle();
                write_cfg(rows[i].a24, rows[i].nbits);
            end
            send_word(rows[i].mode, rows[i].index, rows[i].value, rows[i].zero_result);
        end

        start <= 1'b0;
        wait_idle();
        write_cfg($urandom, 9'($urandom_range(1, 20)));
        n_start = 0;
        for (int i = 0; i < 150; i++)
        begin
            no_idle = (i >= 50 && i < 100);
            r = $urandom_range(0, 99);
            if (r < 3 && n_start < 3)
            begin
                m = MODE_START;
                n_start++;
            end
            else if (r < 8)
                m = 2'd3;
            else
                m = (r < 54) ? MODE_SCALAR : MODE_COORD;
            send_word(m, 2'($urandom_range(0, 3)), {$urandom, $urandom}, 1'b0);
        end
        if (n_start == 0)
            send_word(MODE_START, 2'd0, {$urandom, $urandom}, 1'b0);
        start <= 1'b0;

        wait_idle();
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> montgomery_ladder_scalar_mult.f
src/mlsm_pkg.sv
src/mlsm_regfile.sv
src/mlsm_alu.sv
src/montgomery_ladder_scalar_mult.sv
sim/tb_top.sv
